/* rtl/core/rbpp_pkg.sv */
// ----------------------------------------------------------------------------
// rbpp_pkg
// Shared types, register indexes, format codes and the channel rescale
// function for the RGBA to bitmap pixel packer.
// ----------------------------------------------------------------------------
package rbpp_pkg;

	// default image row limit in pixels
	localparam int MAX_WIDTH_DEF = 4096;

	// configuration port widths
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd1;

	// output format codes (bit 1 selects the 24-bit path)
	localparam logic [1:0] FMT_RGB555 = 2'd0;
	localparam logic [1:0] FMT_RGB565 = 2'd1;
	localparam logic [1:0] FMT_RGB888 = 2'd2;

	// bytes per packed pixel
	localparam logic [1:0] BYTES_16 = 2'd2;
	localparam logic [1:0] BYTES_24 = 2'd3;

	// channel full-scale values
	localparam logic [5:0] LEVELS_5 = 6'd31;
	localparam logic [5:0] LEVELS_6 = 6'd63;

	// source pixel, red in the lowest byte
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgba_t;

	// configuration register contents
	typedef struct packed {
		logic [1:0]            pixel_format;
		logic [CFG_DATA_W-1:0] line_width;
	} cfg_t;

	// row position flags for one pixel
	typedef struct packed {
		logic       row_end;
		logic [1:0] pad_bytes;
	} row_info_t;

	// rounded rescale (c*levels*2+255)/510, done as floor((c*levels+127)/255)
	// with the exact divide-by-255 identity (y + (y>>8) + 1) >> 8
	function automatic logic [5:0] rescale(input logic [7:0] c, input logic [5:0] levels);
		logic [13:0] y;
		logic [13:0] s;
		y = 14'({6'b0, c} * {8'b0, levels}) + 14'd127;
		s = y + (y >> 8) + 14'd1;
		return s[13:8];
	endfunction

endpackage

/* rtl/core/rgba_to_bmp_pixel_packer_top.sv */
// ----------------------------------------------------------------------------
// rgba_to_bmp_pixel_packer_top
// RGBA8888 to bitmap pixel packer with row-end and stride padding flags.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and delivers one packed pixel per clock while the
// output is not stalled; each pixel passes through the input register and then
// the result register, with the rescale and packing logic between them.
// Both stages move on their own, so a stalled result holds off the input only
// once the input register is full as well; the input ready follows the output
// ready combinationally. Write the configuration registers only while no
// pixel is in flight; the column counter is kept across writes.
module rgba_to_bmp_pixel_packer_top #(
	parameter int MAX_WIDTH = rbpp_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// slave side
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [31:0]                    s_axis_tdata,  // red, green, blue, alpha
	// master side
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [31:0]                    m_axis_tdata,  // packed_pixel, byte_count, pad_bytes, zero fill
	output logic                           m_axis_tlast,  // row_end
	// configuration write
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rbpp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbpp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rbpp_pkg::*;

	cfg_t      cfg;
	rgba_t     pixel_s1;
	logic      valid_s1;
	logic      ready_s1;
	logic      advance;
	logic [23:0] packed_pixel;
	logic [1:0]  byte_count;
	row_info_t row_info;
	logic        valid_s2;
	logic [23:0] packed_pixel_s2;
	logic [1:0]  byte_count_s2;
	row_info_t   row_info_s2;

	assign cfg_ready = 1'b1;

	rbpp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage handshakes
	assign ready_s1      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && ready_s1;
	assign s_axis_tready = !valid_s1 || ready_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			pixel_s1 <= rgba_t'(s_axis_tdata);
		end
	end

	rbpp_pixel_pack u_pack (
		.pixel        (pixel_s1),
		.pixel_format (cfg.pixel_format),
		.packed_pixel (packed_pixel),
		.byte_count   (byte_count)
	);

	rbpp_row_track #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_row (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.line_width (cfg.line_width),
		.wide_pixel (cfg.pixel_format[1]),
		.row_info   (row_info)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			packed_pixel_s2 <= packed_pixel;
			byte_count_s2   <= byte_count;
			row_info_s2     <= row_info;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'd0, row_info_s2.pad_bytes, byte_count_s2, packed_pixel_s2};
	assign m_axis_tlast  = row_info_s2.row_end;

endmodule

/* rtl/core/rbpp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rbpp_cfg_regs
// Configuration registers: pixel format and line width.
// ----------------------------------------------------------------------------
module rbpp_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [rbpp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbpp_pkg::CFG_DATA_W-1:0] cfg_data,
	output rbpp_pkg::cfg_t                 cfg
);
	import rbpp_pkg::*;

	cfg_t cfg_q;

	// register write on each config transfer, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_format <= FMT_RGB555;
			cfg_q.line_width   <= CFG_DATA_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PIXEL_FORMAT: cfg_q.pixel_format <= cfg_data[1:0];
				REG_LINE_WIDTH:   cfg_q.line_width   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/rbpp_pixel_pack.sv */
// ----------------------------------------------------------------------------
// rbpp_pixel_pack
// Rescales and packs one RGBA pixel into RGB555, RGB565 or RGB888.
// ----------------------------------------------------------------------------
module rbpp_pixel_pack (
	input  rbpp_pkg::rgba_t pixel,
	input  logic [1:0]      pixel_format,
	output logic [23:0]     packed_pixel,
	output logic [1:0]      byte_count
);
	import rbpp_pkg::*;

	logic [5:0]  r5;
	logic [5:0]  g5;
	logic [5:0]  g6;
	logic [5:0]  b5;
	logic [15:0] word16;

	// per-channel rounding rescale
	assign r5 = rescale(pixel.red,   LEVELS_5);
	assign g5 = rescale(pixel.green, LEVELS_5);
	assign g6 = rescale(pixel.green, LEVELS_6);
	assign b5 = rescale(pixel.blue,  LEVELS_5);

	// 16-bit word, cleared for transparent pixels
	always_comb begin
		if (pixel_format == FMT_RGB565) begin
			word16 = {r5[4:0], g6, b5[4:0]};
		end else begin
			word16 = {1'b0, r5[4:0], g5[4:0], b5[4:0]};
		end
		if (pixel.alpha == 8'd0) begin
			word16 = '0;
		end
	end

	// 24-bit pass-through or 16-bit word
	always_comb begin
		if (pixel_format[1]) begin
			packed_pixel = {pixel.red, pixel.green, pixel.blue};
			byte_count   = BYTES_24;
		end else begin
			packed_pixel = {8'd0, word16};
			byte_count   = BYTES_16;
		end
	end

endmodule

/* rtl/core/rbpp_row_track.sv */
// ----------------------------------------------------------------------------
// rbpp_row_track
// Column counter that flags the last pixel of each row and works out the
// zero padding up to a 4-byte row stride.
// ----------------------------------------------------------------------------
module rbpp_row_track #(
	parameter int MAX_WIDTH = rbpp_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           advance,
	input  logic [rbpp_pkg::CFG_DATA_W-1:0] line_width,
	input  logic                           wide_pixel,
	output rbpp_pkg::row_info_t            row_info
);
	import rbpp_pkg::*;

	localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int EW_RAW = $clog2(MAX_WIDTH + 1);
	localparam int EW     = (EW_RAW > 2) ? EW_RAW : 2;

	logic [CW-1:0] column_count_q;
	logic [EW-1:0] width_eff;
	logic          last_col;

	// width clamped to 1..MAX_WIDTH
	always_comb begin
		if (line_width == '0) begin
			width_eff = EW'(1);
		end else if (32'(line_width) > 32'(MAX_WIDTH)) begin
			width_eff = EW'(MAX_WIDTH);
		end else begin
			width_eff = EW'(line_width);
		end
	end

	assign last_col = ({1'b0, EW'(column_count_q)} + (EW+1)'(1)) >= {1'b0, width_eff};

	// row flags; padding is width mod 4 for 3-byte pixels, 2*(width odd) for 2-byte
	always_comb begin
		row_info.row_end = last_col;
		if (!last_col) begin
			row_info.pad_bytes = 2'd0;
		end else if (wide_pixel) begin
			row_info.pad_bytes = width_eff[1:0];
		end else begin
			row_info.pad_bytes = {width_eff[0], 1'b0};
		end
	end

	// column counter, steps once per pixel transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
		end else if (advance) begin
			if (last_col) begin
				column_count_q <= '0;
			end else begin
				column_count_q <= column_count_q + CW'(1);
			end
		end
	end

endmodule

/* rtl/core/rbpp_checker.sv */
// ----------------------------------------------------------------------------
// rbpp_checker
// Port-level checks for the pixel packer, bound to the top level.
// ----------------------------------------------------------------------------
module rbpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// byte count is always two or three
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[25:24] == 2'd2 || m_axis_tdata[25:24] == 2'd3))
		else $error("bad byte count");

	// padding only on the last pixel of a row
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[27:26] == 2'd0)
		else $error("padding outside row end");

	// 16-bit pixels leave the top byte clear, 2-byte rows pad to 0 or 2
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[25:24] == 2'd2 |->
			m_axis_tdata[23:16] == 8'd0 && !m_axis_tdata[26])
		else $error("16-bit pixel with bad upper byte or padding");

endmodule

bind rgba_to_bmp_pixel_packer_top rbpp_checker u_rbpp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
